// ===== hdl/counting_semaphore_wait_queue_assert.svh =====
// Assertion macros used by the checker file.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CSQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("semaphore check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define CSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("semaphore check failed: next-cycle rule");

`endif

// ===== hdl/csq_pkg.sv =====
package csq_pkg;

   // request kinds
   localparam logic [1:0] KIND_OBTAIN  = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   // response status codes
   localparam logic [2:0] ST_GRANTED     = 3'd0;
   localparam logic [2:0] ST_BUSY        = 3'd1;
   localparam logic [2:0] ST_QUEUED      = 3'd2;
   localparam logic [2:0] ST_TIMED_OUT   = 3'd3;
   localparam logic [2:0] ST_NOT_WAITING = 3'd4;
   localparam logic [2:0] ST_QUEUE_FULL  = 3'd5;
   localparam logic [2:0] ST_RELEASED    = 3'd6;

   // register indexes
   localparam int         CSR_INDEX_W     = 2;
   localparam logic [1:0] CSR_INIT_COUNT  = 2'd0;
   localparam logic [1:0] CSR_MAX_COUNT   = 2'd1;
   localparam logic [1:0] CSR_ORDER_MODE  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] task_id;
      logic [7:0] task_priority;
      logic       may_wait;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       woken_valid;
      logic [7:0] woken_task;
   } rsp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_INSERT,
      SEQ_REMOVE
   } csq_state_type;

endpackage

// ===== hdl/counting_semaphore_wait_queue.sv =====
// Channel   | Ports                                       | Handshake
// ----------+---------------------------------------------+------------------------------
// request   | start, busy, req_data                       | taken when start && !busy
// response  | rsp_strobe, rsp_data                        | one-cycle strobe, no stall
// config    | csr_valid, csr_ready, csr_index, csr_wdata  | written when valid && ready
//
// Grant, busy, full, FIFO enqueue and empty-queue cases answer in the cycle after start.
// Priority insert, release with waiters and timeout sweep the wait queue memory one entry
// per cycle over its single read port.
// busy stays high during a sweep; the response strobes the cycle after it ends.
// Sync reset clears count, queue length, init, mode (max to 1); no memory clearing pass.
module counting_semaphore_wait_queue import csq_pkg::*; #(
   parameter int MAX_WAITERS  = 16,
   parameter int TASK_ID_BITS = 8,
   parameter int PRIO_BITS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int CW = $clog2(MAX_WAITERS + 1);
   localparam int EW = TASK_ID_BITS + PRIO_BITS;

   // wait queue memory: {id, priority} per entry, kept in service order
   logic [EW-1:0] queue_mem [MAX_WAITERS];
   logic [EW-1:0] rd_q;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;

   csq_state_type state_ff, state_in;
   logic [7:0]    count_ff, count_in;
   logic [CW-1:0] total_ff, total_in;
   logic [7:0]    init_ff, init_in;
   logic [7:0]    max_ff, max_in;
   logic          mode_ff, mode_in;
   logic [EW-1:0] carry_ff, carry_in;
   logic [TASK_ID_BITS-1:0] key_id_ff, key_id_in;
   logic [PRIO_BITS-1:0]    key_prio_ff, key_prio_in;
   logic [CW-1:0] ridx_ff, ridx_in;
   logic          pv_ff, pv_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          shift_ff, shift_in;
   logic          found_ff, found_in;
   logic          rel_ff, rel_in;
   logic [TASK_ID_BITS-1:0] woken_ff, woken_in;
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;

   logic [TASK_ID_BITS-1:0] req_id;
   logic [PRIO_BITS-1:0]    req_prio;
   logic [TASK_ID_BITS-1:0] q_id;
   logic [PRIO_BITS-1:0]    q_prio;
   logic          take;
   logic          go_insert;
   logic          go_remove;
   logic          sweep_done;
   logic          csr_write;

   assign req_id   = TASK_ID_BITS'(req_data.task_id);
   assign req_prio = PRIO_BITS'(req_data.task_priority);
   assign q_id     = rd_q[EW-1:PRIO_BITS];
   assign q_prio   = rd_q[PRIO_BITS-1:0];
   assign take     = start && !busy;
   assign rd_addr  = ridx_ff[AW-1:0];
   assign csr_write = csr_valid && csr_ready;

   // decide which requests need a queue sweep
   always_comb begin
      go_insert = take && (req_data.kind == KIND_OBTAIN) && (count_ff == 8'd0)
                  && req_data.may_wait && (total_ff != CW'(MAX_WAITERS))
                  && mode_ff && (total_ff != '0);
      go_remove = take && ((req_data.kind == KIND_RELEASE) || (req_data.kind == KIND_TIMEOUT))
                  && (total_ff != '0);
      sweep_done = !pv_ff && (ridx_ff == total_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (go_insert) begin
               state_in = SEQ_INSERT;
            end else if (go_remove) begin
               state_in = SEQ_REMOVE;
            end
         end
         SEQ_INSERT, SEQ_REMOVE: begin
            if (sweep_done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      busy      = 1'b0;
      csr_ready = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            csr_ready = 1'b1;
         end
         SEQ_INSERT, SEQ_REMOVE: begin
            busy  = 1'b1;
            rd_en = (ridx_ff < total_ff);
         end
         default: busy = 1'b1;
      endcase
   end

   // datapath: immediate answers, sweep steps, register writes
   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      init_in     = init_ff;
      max_in      = max_ff;
      mode_in     = mode_ff;
      carry_in    = carry_ff;
      key_id_in   = key_id_ff;
      key_prio_in = key_prio_ff;
      ridx_in     = ridx_ff;
      pv_in       = 1'b0;
      pidx_in     = pidx_ff;
      shift_in    = shift_ff;
      found_in    = found_ff;
      rel_in      = rel_ff;
      woken_in    = woken_ff;
      rsp_in      = '0;
      strobe_in   = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;

      case (state_ff)
         SEQ_IDLE: begin
            // set up a sweep from the head
            ridx_in     = '0;
            shift_in    = 1'b0;
            found_in    = 1'b0;
            rel_in      = (req_data.kind == KIND_RELEASE);
            key_id_in   = req_id;
            key_prio_in = req_prio;
            carry_in    = {req_id, req_prio};
            if (take) begin
               case (req_data.kind)
                  KIND_OBTAIN: begin
                     strobe_in = 1'b1;
                     if (count_ff != 8'd0) begin
                        count_in      = count_ff - 8'd1;
                        rsp_in.status = ST_GRANTED;
                     end else if (!req_data.may_wait) begin
                        rsp_in.status = ST_BUSY;
                     end else if (total_ff == CW'(MAX_WAITERS)) begin
                        rsp_in.status = ST_QUEUE_FULL;
                     end else if (go_insert) begin
                        strobe_in = 1'b0;
                     end else begin
                        // append at the tail
                        mem_we        = 1'b1;
                        mem_waddr     = total_ff[AW-1:0];
                        mem_wdata     = {req_id, req_prio};
                        total_in      = total_ff + 1'b1;
                        rsp_in.status = ST_QUEUED;
                     end
                  end
                  KIND_RELEASE: begin
                     if (!go_remove) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_RELEASED;
                        if (count_ff < max_ff) begin
                           count_in = count_ff + 8'd1;
                        end
                     end
                  end
                  KIND_TIMEOUT: begin
                     if (!go_remove) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_NOT_WAITING;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // configuration writes
            if (csr_write) begin
               case (csr_index)
                  CSR_INIT_COUNT: begin
                     init_in  = csr_wdata;
                     count_in = csr_wdata;
                     total_in = '0;
                  end
                  CSR_MAX_COUNT:  max_in  = csr_wdata;
                  CSR_ORDER_MODE: mode_in = csr_wdata[0];
                  default: begin
                  end
               endcase
            end
         end
         SEQ_INSERT, SEQ_REMOVE: begin
            // issue the next read
            if (ridx_ff < total_ff) begin
               pv_in   = 1'b1;
               pidx_in = ridx_ff[AW-1:0];
               ridx_in = ridx_ff + 1'b1;
            end
            if (pv_ff) begin
               if (state_ff == SEQ_INSERT) begin
                  // from the first lower-priority entry on, ripple entries one slot back
                  if (shift_ff || (q_prio > key_prio_ff)) begin
                     mem_we    = 1'b1;
                     mem_waddr = pidx_ff;
                     mem_wdata = carry_ff;
                     carry_in  = rd_q;
                     shift_in  = 1'b1;
                  end
               end else begin
                  // after the match, pull entries one slot forward
                  if (found_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = pidx_ff - 1'b1;
                     mem_wdata = rd_q;
                  end else if (rel_ff || (q_id == key_id_ff)) begin
                     found_in = 1'b1;
                     woken_in = q_id;
                  end
               end
            end else if (sweep_done) begin
               strobe_in = 1'b1;
               if (state_ff == SEQ_INSERT) begin
                  mem_we        = 1'b1;
                  mem_waddr     = total_ff[AW-1:0];
                  mem_wdata     = carry_ff;
                  total_in      = total_ff + 1'b1;
                  rsp_in.status = ST_QUEUED;
               end else if (found_ff) begin
                  total_in = total_ff - 1'b1;
                  if (rel_ff) begin
                     rsp_in.status      = ST_RELEASED;
                     rsp_in.woken_valid = 1'b1;
                     rsp_in.woken_task  = 8'(woken_ff);
                  end else begin
                     rsp_in.status = ST_TIMED_OUT;
                  end
               end else begin
                  rsp_in.status = ST_NOT_WAITING;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_q <= queue_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SEQ_IDLE;
         count_ff  <= 8'd0;
         total_ff  <= '0;
         init_ff   <= 8'd0;
         max_ff    <= 8'd1;
         mode_ff   <= 1'b0;
         pv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         init_ff   <= init_in;
         max_ff    <= max_in;
         mode_ff   <= mode_in;
         pv_ff     <= pv_in;
         strobe_ff <= strobe_in;
      end
   end

   // sweep and response payload
   always_ff @(posedge clock) begin
      carry_ff    <= carry_in;
      key_id_ff   <= key_id_in;
      key_prio_ff <= key_prio_in;
      ridx_ff     <= ridx_in;
      pidx_ff     <= pidx_in;
      shift_ff    <= shift_in;
      found_ff    <= found_in;
      rel_ff      <= rel_in;
      woken_ff    <= woken_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hdl/csq_checker.sv =====
`include "counting_semaphore_wait_queue_assert.svh"

module csq_checker import csq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input req_type                req_data,
   input logic                   rsp_strobe,
   input rsp_type                rsp_data
);

   // results only show once the sweep is over
   `CSQ_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy)

   // the end of a sweep delivers its result in the first idle cycle
   `CSQ_ASSERT_NOW(a_sweep_rsp, clock, reset, $fell(busy), rsp_strobe)

   // a taken request either answers next cycle or starts a sweep
   `CSQ_ASSERT_NEXT(a_take, clock, reset,
                    start && !busy && (req_data.kind != KIND_NONE), rsp_strobe || busy)

   // only a release wakes a task
   `CSQ_ASSERT_NOW(a_wake, clock, reset,
                   rsp_strobe && rsp_data.woken_valid, rsp_data.status == ST_RELEASED)

   // no wake means an empty task field
   `CSQ_ASSERT_NOW(a_nowake, clock, reset,
                   rsp_strobe && !rsp_data.woken_valid, rsp_data.woken_task == 8'd0)

endmodule

bind counting_semaphore_wait_queue csq_checker u_csq_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
   import csq_pkg::*;

   localparam int QUEUE_DEPTH = 16;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0] csr_wdata;

   counting_semaphore_wait_queue u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // semaphore shadow state
   logic [7:0] sem_init;
   logic [7:0] sem_max;
   logic       sem_prio_order;
   logic [7:0] sem_count;
   logic [7:0] wait_ids[QUEUE_DEPTH];
   logic [7:0] wait_prios[QUEUE_DEPTH];
   int         wait_len;

   rsp_type    pending_rsps[$];
   int         fail_count;
   int         send_idle_pct;

   // register settings walked by the random phases
   logic [7:0] init_vals[4] = '{8'd0, 8'd255, 8'd3, 8'd1};
   logic [7:0] max_vals[4]  = '{8'd0, 8'd255, 8'd4, 8'd2};

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // remove waiter at pos, closing the gap
   function automatic void remove_waiter(input int pos);
      for (int i = pos; i < wait_len - 1; i++) begin
         wait_ids[i]   = wait_ids[i + 1];
         wait_prios[i] = wait_prios[i + 1];
      end
      wait_len--;
   endfunction

   // advance shadow state by one request and return its response
   function automatic rsp_type sem_apply(input req_type rq);
      rsp_type r;
      int      pos;
      r = '0;
      case (rq.kind)
         KIND_OBTAIN: begin
            if (sem_count != 0) begin
               sem_count--;
               r.status = ST_GRANTED;
            end else if (!rq.may_wait) begin
               r.status = ST_BUSY;
            end else if (wait_len >= QUEUE_DEPTH) begin
               r.status = ST_QUEUE_FULL;
            end else begin
               pos = wait_len;
               if (sem_prio_order) begin
                  for (int i = 0; i < wait_len; i++) begin
                     if (wait_prios[i] > rq.task_priority) begin
                        pos = i;
                        break;
                     end
                  end
               end
               for (int i = wait_len; i > pos; i--) begin
                  wait_ids[i]   = wait_ids[i - 1];
                  wait_prios[i] = wait_prios[i - 1];
               end
               wait_ids[pos]   = rq.task_id;
               wait_prios[pos] = rq.task_priority;
               wait_len++;
               r.status = ST_QUEUED;
            end
         end
         KIND_RELEASE: begin
            if (wait_len > 0) begin
               r.woken_valid = 1'b1;
               r.woken_task  = wait_ids[0];
               remove_waiter(0);
            end else if (sem_count < sem_max) begin
               sem_count++;
            end
            r.status = ST_RELEASED;
         end
         default: begin
            r.status = ST_NOT_WAITING;
            for (int i = 0; i < wait_len; i++) begin
               if (wait_ids[i] == rq.task_id) begin
                  remove_waiter(i);
                  r.status = ST_TIMED_OUT;
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   // check each strobed response against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            fail_count++;
         end else begin
            exp_rsp = pending_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.woken_valid !== exp_rsp.woken_valid) begin
               $error("woken_valid exp %0d got %0d", exp_rsp.woken_valid,
                      rsp_data.woken_valid);
               fail_count++;
            end
            if (rsp_data.woken_task !== exp_rsp.woken_task) begin
               $error("woken_task exp %0d got %0d", exp_rsp.woken_task,
                      rsp_data.woken_task);
               fail_count++;
            end
         end
      end
   end

   // write one register while the block is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         CSR_INIT_COUNT: begin
            sem_init  = val;
            sem_count = val;
            wait_len  = 0;
         end
         CSR_MAX_COUNT:  sem_max = val;
         default:        sem_prio_order = val[0];
      endcase
   endtask

   // issue one request; check against exp_rsp when given
   task automatic send_req(input req_type rq, input bit typed_exp = 0,
                           input rsp_type exp_rsp = '0);
      rsp_type r;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      start    = 1'b1;
      req_data = rq;
      do @(posedge clock); while (busy);
      if (rq.kind != KIND_NONE) begin
         r = sem_apply(rq);
         if (typed_exp && r != exp_rsp) begin
            $error("predictor disagrees with table: exp %p got %p", exp_rsp, r);
            fail_count++;
         end
         pending_rsps.push_back(r);
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   // hold until every expected response has arrived, then let the block settle
   task automatic drain();
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (QUEUE_DEPTH + 4) @(negedge clock);
   endtask

   function automatic req_type mk_req(input logic [1:0] k, input logic [7:0] id,
                                      input logic [7:0] pr, input logic mw);
      req_type rq;
      rq.kind = k; rq.task_id = id; rq.task_priority = pr; rq.may_wait = mw;
      return rq;
   endfunction

   function automatic rsp_type mk_rsp(input logic [2:0] st, input logic wv,
                                      input logic [7:0] wt);
      rsp_type r;
      r.status = st; r.woken_valid = wv; r.woken_task = wt;
      return r;
   endfunction

   // one random request with live task ids so timeouts often hit
   function automatic req_type rand_req();
      req_type rq;
      int      pick;
      pick = $urandom_range(99);
      rq.kind = pick < 45 ? KIND_OBTAIN : pick < 80 ? KIND_RELEASE :
                pick < 97 ? KIND_TIMEOUT : KIND_NONE;
      rq.task_id = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom);
      if (rq.kind == KIND_TIMEOUT && wait_len > 0 && $urandom_range(2) != 0)
         rq.task_id = wait_ids[$urandom_range(wait_len - 1)];
      rq.task_priority = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
      rq.may_wait = $urandom_range(4) != 0;
      return rq;
   endfunction

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   stim_row_type dir_table[] = '{
      '{'{KIND_OBTAIN,  8'h00, 8'h00, 1'b0}, 1, '{ST_BUSY, 1'b0, 8'h00}},
      '{'{KIND_TIMEOUT, 8'hFF, 8'h00, 1'b0}, 1, '{ST_NOT_WAITING, 1'b0, 8'h00}},
      '{'{KIND_NONE,    8'h12, 8'h34, 1'b1}, 0, '0},
      '{'{KIND_OBTAIN,  8'hFF, 8'hFF, 1'b1}, 1, '{ST_QUEUED, 1'b0, 8'h00}},
      '{'{KIND_OBTAIN,  8'hAA, 8'h00, 1'b1}, 0, '0},
      '{'{KIND_OBTAIN,  8'hFF, 8'h80, 1'b1}, 0, '0},
      '{'{KIND_TIMEOUT, 8'hFF, 8'h00, 1'b0}, 0, '0},
      '{'{KIND_TIMEOUT, 8'h55, 8'h00, 1'b0}, 1, '{ST_NOT_WAITING, 1'b0, 8'h00}},
      '{'{KIND_RELEASE, 8'h00, 8'h00, 1'b0}, 0, '0},
      '{'{KIND_RELEASE, 8'h00, 8'h00, 1'b0}, 0, '0},
      '{'{KIND_RELEASE, 8'h00, 8'h00, 1'b0}, 1, '{ST_RELEASED, 1'b0, 8'h00}},
      '{'{KIND_RELEASE, 8'h00, 8'h00, 1'b0}, 1, '{ST_RELEASED, 1'b0, 8'h00}},
      '{'{KIND_OBTAIN,  8'h01, 8'h01, 1'b0}, 1, '{ST_GRANTED, 1'b0, 8'h00}},
      '{'{KIND_OBTAIN,  8'h01, 8'h01, 1'b0}, 1, '{ST_BUSY, 1'b0, 8'h00}}
   };

   initial begin
      fail_count = 0;
      send_idle_pct = 0;
      reset = 1'b1; start = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      sem_init = 8'd0; sem_max = 8'd1; sem_prio_order = 1'b0;
      sem_count = 8'd0; wait_len = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed table, reset defaults then priority mode
      foreach (dir_table[i]) send_req(dir_table[i].rq, dir_table[i].typed, dir_table[i].rsp);
      drain();
      write_reg(CSR_ORDER_MODE, 1'b1);
      write_reg(CSR_INIT_COUNT, 8'd0);
      send_req(mk_req(KIND_OBTAIN, 8'h10, 8'h05, 1'b1));
      send_req(mk_req(KIND_OBTAIN, 8'h11, 8'h02, 1'b1));
      send_req(mk_req(KIND_OBTAIN, 8'h12, 8'h05, 1'b1));
      send_req(mk_req(KIND_RELEASE, 8'h00, 8'h00, 1'b0), 1, mk_rsp(ST_RELEASED, 1'b1, 8'h11));
      for (int i = 0; i < 15; i++) send_req(mk_req(KIND_OBTAIN, 8'(i), 8'(i), 1'b1));
      send_req(mk_req(KIND_OBTAIN, 8'h77, 8'h00, 1'b1), 1, mk_rsp(ST_QUEUE_FULL, 1'b0, 8'h00));
      drain();

      // random phases across register settings and idle profiles
      for (int ph = 0; ph < 12; ph++) begin
         send_idle_pct = ph < 4 ? 10 : ph < 8 ? 77 : 0;
         write_reg(CSR_MAX_COUNT, max_vals[ph % 4]);
         write_reg(CSR_ORDER_MODE, 1'(ph / 2));
         write_reg(CSR_INIT_COUNT, init_vals[(ph + 1) % 4]);
         for (int n = 0; n < 75; n++) send_req(rand_req());
         drain();
      end

      if (fail_count == 0)
         $display("[counting_semaphore_wait_queue] OK");
      else
         $display("[counting_semaphore_wait_queue] ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("[counting_semaphore_wait_queue] ERROR");
      $finish;
   end

endmodule
